>>> rtl/core/kmhr_pkg.sv
// ----------------------------------------------------------------------------
// kmhr_pkg: shared types and constants of the key matrix hold/repeat unit
// Field widths, stream packing, register indexes, reset values and the
// default values of the top-level parameters.
// ----------------------------------------------------------------------------
package kmhr_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned DefNumCols       = 4;
  localparam int unsigned DefNumRows       = 2;
  localparam int unsigned DefCountWidth    = 16;
  localparam int unsigned DefRepeatPeriod  = 3;

  // Rows that carry an input field; further rows read as released.
  localparam int unsigned InputRows  = 2;
  localparam int unsigned RowFieldW  = 4;
  localparam int unsigned LevelW     = 8;
  localparam int unsigned BitmapW    = 8;

  // Input stream packing: row0_columns, row1_columns.
  localparam int unsigned InTdataW   = 8;

  // Output stream packing from bit 0 up.
  localparam int unsigned OutEdgesLsb   = 0;
  localparam int unsigned OutHeldLsb    = 8;
  localparam int unsigned OutEscapeBit  = 16;
  localparam int unsigned OutConfirmBit = 17;
  localparam int unsigned OutIncBit     = 18;
  localparam int unsigned OutDecBit     = 19;
  localparam int unsigned OutUsedW      = 20;
  localparam int unsigned OutTdataW     = 24;

  // Configuration port.
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 2;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ESCAPE_HOLD  = 2'd0,
    REG_CONFIRM_HOLD = 2'd1,
    REG_REPEAT_START = 2'd2
  } kmhr_reg_e;

  localparam logic [CfgDataW-1:0] EscapeHoldRst  = 16'd5;
  localparam logic [CfgDataW-1:0] ConfirmHoldRst = 16'd10;
  localparam logic [CfgDataW-1:0] RepeatStartRst = 16'd10;

  typedef struct packed {
    logic [CfgDataW-1:0] escape_hold_count;
    logic [CfgDataW-1:0] confirm_hold_count;
    logic [CfgDataW-1:0] repeat_start_count;
  } kmhr_cfg_t;

  // Flags of one result item.
  typedef struct packed {
    logic                escape_hold;
    logic                confirm_hold;
    logic                increase_fire;
    logic                decrease_fire;
  } kmhr_flags_t;

endpackage

>>> rtl/core/kmhr_cfg_regs.sv
// ----------------------------------------------------------------------------
// kmhr_cfg_regs: configuration register file
// Three 16-bit threshold registers written through a valid/ready channel.
// Writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module kmhr_cfg_regs import kmhr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [CfgIndexW-1:0] wr_index_i,
  input  logic [CfgDataW-1:0]  wr_data_i,
  output kmhr_cfg_t            cfg_o
);

  kmhr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (kmhr_reg_e'(wr_index_i))
        REG_ESCAPE_HOLD:  cfg_d.escape_hold_count  = wr_data_i;
        REG_CONFIRM_HOLD: cfg_d.confirm_hold_count = wr_data_i;
        REG_REPEAT_START: cfg_d.repeat_start_count = wr_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_hold_count  <= EscapeHoldRst;
      cfg_q.confirm_hold_count <= ConfirmHoldRst;
      cfg_q.repeat_start_count <= RepeatStartRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/kmhr_counter_bank.sv
// ----------------------------------------------------------------------------
// kmhr_counter_bank: per-key saturating hold counters
// One counter per key plus a per-key phase counter that tracks the hold count modulo
// the repeat period. Both update when a scan tick moves to the result stage.
// ----------------------------------------------------------------------------
module kmhr_counter_bank import kmhr_pkg::*; #(
  parameter int unsigned NUM_COLS         = DefNumCols,
  parameter int unsigned NUM_ROWS_SCANNED = DefNumRows,
  parameter int unsigned COUNT_WIDTH      = DefCountWidth,
  parameter int unsigned REPEAT_PERIOD    = DefRepeatPeriod,
  localparam int unsigned KeyCount        = NUM_ROWS_SCANNED * NUM_COLS,
  localparam int unsigned PhaseW          = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tick_i,
  input  logic [RowFieldW-1:0]                row0_columns_i,
  input  logic [RowFieldW-1:0]                row1_columns_i,
  output logic [KeyCount-1:0][COUNT_WIDTH-1:0] count_next_o,
  output logic [KeyCount-1:0][PhaseW-1:0]      phase_next_o
);

  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(REPEAT_PERIOD - 1);

  logic [KeyCount-1:0][COUNT_WIDTH-1:0] count_q, count_d;
  logic [KeyCount-1:0][PhaseW-1:0]      phase_q, phase_d;

  for (genvar k = 0; k < KeyCount; k++) begin : g_key
    localparam int unsigned Row = k / NUM_COLS;
    localparam int unsigned Col = k % NUM_COLS;
    logic [LevelW-1:0] levels;
    logic              pressed;

    if (Row == 0) begin : g_row0
      assign levels = {{(LevelW-RowFieldW){1'b1}}, row0_columns_i};
    end else if (Row == 1) begin : g_row1
      assign levels = {{(LevelW-RowFieldW){1'b1}}, row1_columns_i};
    end else begin : g_idle_row
      assign levels = '1;
    end

    assign pressed = ~levels[Col];

    always_comb begin
      count_d[k] = count_q[k];
      phase_d[k] = phase_q[k];
      if (!pressed) begin
        count_d[k] = '0;
        phase_d[k] = '0;
      end else if (count_q[k] != '1) begin
        count_d[k] = count_q[k] + 1'b1;
        phase_d[k] = (phase_q[k] == PhaseLast) ? '0 : phase_q[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= '0;
    end else if (tick_i) begin
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

  assign count_next_o = count_d;
  assign phase_next_o = phase_d;

endmodule

>>> rtl/core/kmhr_result_enc.sv
// ----------------------------------------------------------------------------
// kmhr_result_enc: result formation from the updated counters
// Builds the press-edge and held bitmaps and the hold and repeat flags.
// ----------------------------------------------------------------------------
module kmhr_result_enc import kmhr_pkg::*; #(
  parameter int unsigned NUM_COLS         = DefNumCols,
  parameter int unsigned NUM_ROWS_SCANNED = DefNumRows,
  parameter int unsigned COUNT_WIDTH      = DefCountWidth,
  parameter int unsigned REPEAT_PERIOD    = DefRepeatPeriod,
  localparam int unsigned KeyCount        = NUM_ROWS_SCANNED * NUM_COLS,
  localparam int unsigned PhaseW          = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1
) (
  input  logic [KeyCount-1:0][COUNT_WIDTH-1:0] count_i,
  input  logic [KeyCount-1:0][PhaseW-1:0]      phase_i,
  input  kmhr_cfg_t                            cfg_i,
  output logic [BitmapW-1:0]                   press_edges_o,
  output logic [BitmapW-1:0]                   held_keys_o,
  output kmhr_flags_t                          flags_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > CfgDataW) ? COUNT_WIDTH : CfgDataW;
  // Residue of a count of one: zero when every count is a multiple of one.
  localparam logic [PhaseW-1:0] PhaseOne = (REPEAT_PERIOD > 1) ? PhaseW'(1) : '0;

  logic [3:0][CmpW-1:0]   named_count;
  logic [3:0][PhaseW-1:0] named_phase;

  for (genvar b = 0; b < BitmapW; b++) begin : g_bit
    if (b < KeyCount) begin : g_key
      assign press_edges_o[b] = (count_i[b] == COUNT_WIDTH'(1));
      assign held_keys_o[b]   = (count_i[b] != '0);
    end else begin : g_none
      assign press_edges_o[b] = 1'b0;
      assign held_keys_o[b]   = 1'b0;
    end
  end

  // A named key that does not exist reads as an idle counter.
  for (genvar n = 0; n < 4; n++) begin : g_named
    if (n < KeyCount) begin : g_key
      assign named_count[n] = CmpW'(count_i[n]);
      assign named_phase[n] = phase_i[n];
    end else begin : g_none
      assign named_count[n] = '0;
      assign named_phase[n] = '0;
    end
  end

  function automatic logic repeat_fire(input logic [CmpW-1:0]   cnt,
                                       input logic [PhaseW-1:0] phase,
                                       input logic [CfgDataW-1:0] start);
    logic first;
    logic past_start;
    first      = (cnt == CmpW'(1));
    past_start = (cnt > CmpW'(start));
    return first || (past_start && (phase == PhaseOne));
  endfunction

  always_comb begin
    flags_o.escape_hold   = (named_count[0] == CmpW'(cfg_i.escape_hold_count));
    flags_o.confirm_hold  = (named_count[3] == CmpW'(cfg_i.confirm_hold_count));
    flags_o.increase_fire = repeat_fire(named_count[2], named_phase[2],
                                        cfg_i.repeat_start_count);
    flags_o.decrease_fire = repeat_fire(named_count[1], named_phase[1],
                                        cfg_i.repeat_start_count);
  end

endmodule

>>> rtl/core/key_matrix_hold_repeat_unit.sv
// ----------------------------------------------------------------------------
// key_matrix_hold_repeat_unit: keypad scanner with hold detection and repeat
//
//   channel  direction  handshake                 payload
//   s_*      in         s_tvalid_i / s_tready_o   scan tick column levels
//   m_*      out        m_tvalid_o / m_tready_i   bitmaps and event flags
//   cfg_*    in         cfg_valid_i / cfg_ready_o register index and value
//
// One scan tick per cycle sustained while the result stream does not stall; a
// tick is held in the input register, and the counter update loads its result
// into the result register, from which it transfers. Reset clears all hold
// counters and loads the default thresholds; the configuration channel is
// always ready. While the result register is stalled the input register
// still takes one more tick.
// ----------------------------------------------------------------------------
module key_matrix_hold_repeat_unit import kmhr_pkg::*; #(
  parameter int unsigned NUM_COLS         = DefNumCols,
  parameter int unsigned NUM_ROWS_SCANNED = DefNumRows,
  parameter int unsigned COUNT_WIDTH      = DefCountWidth,
  parameter int unsigned REPEAT_PERIOD    = DefRepeatPeriod
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  // [3:0] row0_columns, [7:4] row1_columns
  input  logic [InTdataW-1:0]  s_tdata_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  // [7:0] press_edges, [15:8] held_keys, [16] escape_hold, [17] confirm_hold,
  // [18] increase_fire, [19] decrease_fire, [23:20] zero
  output logic [OutTdataW-1:0] m_tdata_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned KeyCount = NUM_ROWS_SCANNED * NUM_COLS;
  localparam int unsigned PhaseW   = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1;

  logic                 in_valid_q;
  logic [InTdataW-1:0]  in_data_q;
  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q, out_data_d;
  logic                 advance;

  kmhr_cfg_t                            cfg;
  logic [KeyCount-1:0][COUNT_WIDTH-1:0] count_next;
  logic [KeyCount-1:0][PhaseW-1:0]      phase_next;
  logic [BitmapW-1:0]                   press_edges;
  logic [BitmapW-1:0]                   held_keys;
  kmhr_flags_t                          flags;

  // A tick moves on when the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  kmhr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  kmhr_counter_bank #(
    .NUM_COLS         (NUM_COLS),
    .NUM_ROWS_SCANNED (NUM_ROWS_SCANNED),
    .COUNT_WIDTH      (COUNT_WIDTH),
    .REPEAT_PERIOD    (REPEAT_PERIOD)
  ) u_bank (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (advance),
    .row0_columns_i (in_data_q[RowFieldW-1:0]),
    .row1_columns_i (in_data_q[2*RowFieldW-1:RowFieldW]),
    .count_next_o   (count_next),
    .phase_next_o   (phase_next)
  );

  kmhr_result_enc #(
    .NUM_COLS         (NUM_COLS),
    .NUM_ROWS_SCANNED (NUM_ROWS_SCANNED),
    .COUNT_WIDTH      (COUNT_WIDTH),
    .REPEAT_PERIOD    (REPEAT_PERIOD)
  ) u_enc (
    .count_i       (count_next),
    .phase_i       (phase_next),
    .cfg_i         (cfg),
    .press_edges_o (press_edges),
    .held_keys_o   (held_keys),
    .flags_o       (flags)
  );

  always_comb begin
    out_data_d = '0;
    out_data_d[OutEdgesLsb +: BitmapW] = press_edges;
    out_data_d[OutHeldLsb +: BitmapW]  = held_keys;
    out_data_d[OutEscapeBit]           = flags.escape_hold;
    out_data_d[OutConfirmBit]          = flags.confirm_hold;
    out_data_d[OutIncBit]              = flags.increase_fire;
    out_data_d[OutDecBit]              = flags.decrease_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tvalid_i && s_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_data_q <= s_tdata_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

>>> rtl/core/kmhr_checker.sv
// ----------------------------------------------------------------------------
// kmhr_checker: port-level checks of the key matrix hold/repeat unit
// Watches the result stream for consistency between bitmaps and flags.
// ----------------------------------------------------------------------------
module kmhr_checker import kmhr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_tvalid_o,
  input logic                 m_tready_i,
  input logic [OutTdataW-1:0] m_tdata_o
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result changed while stalled");

  // A key on its first tick is also reported as held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ((m_tdata_o[OutEdgesLsb +: BitmapW]
                     & ~m_tdata_o[OutHeldLsb +: BitmapW]) == '0))
    else $error("press edge without held key");

  // Repeat events come only from a held increase or decrease key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[OutIncBit] |-> m_tdata_o[OutHeldLsb + 2])
    else $error("increase fired while key 2 released");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[OutDecBit] |-> m_tdata_o[OutHeldLsb + 1])
    else $error("decrease fired while key 1 released");

  // Padding above the flags stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[OutTdataW-1:OutUsedW] == '0))
    else $error("nonzero padding in result");

endmodule

bind key_matrix_hold_repeat_unit kmhr_checker u_kmhr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for key_matrix_hold_repeat_unit
// Drives scan ticks over the input stream with bursty idling, stalls the
// result stream on a changing pattern, and compares every result transfer
// with a cycle-free model of the per-key hold counters. Thresholds are
// reprogrammed between phases, including zero, one and full-scale values.
// ----------------------------------------------------------------------------
module testbench;
  import kmhr_pkg::*;

  localparam int unsigned NumKeys    = DefNumCols * DefNumRows;
  localparam int unsigned CycleLimit = 3_000_000;
  // The configuration index that maps to no register.
  localparam logic [CfgIndexW-1:0] RegUnused = 2'd3;
  localparam logic [DefCountWidth-1:0] CountMax = '1;

  typedef struct packed {
    logic [BitmapW-1:0] press_edges;
    logic [BitmapW-1:0] held_keys;
    logic               escape_hold;
    logic               confirm_hold;
    logic               increase_fire;
    logic               decrease_fire;
  } key_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid_i = 1'b0;
  logic                 s_tready_o;
  // [3:0] row0_columns, [7:4] row1_columns
  logic [InTdataW-1:0]  s_tdata_i = '1;
  logic                 m_tvalid_o;
  logic                 m_tready_i = 1'b0;
  // [7:0] press_edges, [15:8] held_keys, [16] escape_hold, [17] confirm_hold,
  // [18] increase_fire, [19] decrease_fire, [23:20] zero
  logic [OutTdataW-1:0] m_tdata_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  logic [DefCountWidth-1:0] hold_count [NumKeys];
  kmhr_cfg_t                thresholds;
  key_report_t              expected_reports [$];
  int unsigned              burst_left = 0;
  int unsigned              error_count = 0;
  int unsigned              cycle_count = 0;
  logic [31:0]              ready_pattern = '0;
  logic [5:0]               pattern_age = '0;

  key_matrix_hold_repeat_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("key_matrix_hold_repeat_unit test failed");
      $finish;
    end
  end

  // The receiver stalls on a rotating pattern that is redrawn whenever the
  // 6-bit pattern age wraps; some draws never stall, others stall most of the time.
  always @(posedge clk_i) begin
    if (pattern_age == '0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= '1;
        1: ready_pattern <= $urandom;
        2: ready_pattern <= $urandom | $urandom;
        default: ready_pattern <= $urandom & $urandom;
      endcase
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[31:1]};
    end
    pattern_age <= pattern_age + 1'b1;
    m_tready_i  <= ready_pattern[0];
  end

  function automatic logic repeat_step(logic [DefCountWidth-1:0] count);
    return (count == 1) ||
           ((count > thresholds.repeat_start_count) &&
            ((count % DefRepeatPeriod) == (1 % DefRepeatPeriod)));
  endfunction

  // Advances the hold counters by one scan tick; bit k of pressed is key k.
  function automatic key_report_t advance_counters(logic [NumKeys-1:0] pressed);
    key_report_t report;
    report = '0;
    for (int k = 0; k < NumKeys; k++) begin
      if (!pressed[k]) begin
        hold_count[k] = '0;
      end else if (hold_count[k] != CountMax) begin
        hold_count[k] = hold_count[k] + 1'b1;
      end
      report.press_edges[k] = (hold_count[k] == 1);
      report.held_keys[k]   = (hold_count[k] != 0);
    end
    report.escape_hold   = (hold_count[0] == thresholds.escape_hold_count);
    report.confirm_hold  = (hold_count[3] == thresholds.confirm_hold_count);
    report.increase_fire = repeat_step(hold_count[2]);
    report.decrease_fire = repeat_step(hold_count[1]);
    return report;
  endfunction

  // Mostly holds the current keys, sometimes flips one, now and then jumps.
  function automatic logic [NumKeys-1:0] next_press_mask(logic [NumKeys-1:0] held);
    logic [NumKeys-1:0] mask;
    mask = held;
    case ($urandom_range(0, 39))
      0, 1:    mask = NumKeys'($urandom);
      2:       mask = '0;
      3:       mask = '1;
      4, 5, 6, 7: mask[$urandom_range(0, NumKeys - 1)] ^= 1'b1;
      default: ;
    endcase
    return mask;
  endfunction

  // Sends one scan tick; levels are active low, so the pressed mask inverts.
  task automatic scan_tick(input logic [NumKeys-1:0] pressed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        s_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= ~pressed;
    do @(posedge clk_i); while (!s_tready_o);
    expected_reports.push_back(advance_counters(pressed));
    burst_left--;
  endtask

  // Stops the input stream and waits until every report has come back.
  task automatic settle();
    s_tvalid_i <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIndexW-1:0] index,
                                input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      REG_ESCAPE_HOLD:  thresholds.escape_hold_count  = value;
      REG_CONFIRM_HOLD: thresholds.confirm_hold_count = value;
      REG_REPEAT_START: thresholds.repeat_start_count = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_thresholds(input logic [CfgDataW-1:0] escape,
                                    input logic [CfgDataW-1:0] confirm,
                                    input logic [CfgDataW-1:0] start);
    settle();
    write_register(REG_ESCAPE_HOLD, escape);
    write_register(REG_CONFIRM_HOLD, confirm);
    write_register(REG_REPEAT_START, start);
  endtask

  task automatic random_scan(input int unsigned ticks);
    logic [NumKeys-1:0] mask;
    mask = '0;
    repeat (ticks) begin
      mask = next_press_mask(mask);
      scan_tick(mask);
    end
  endtask

  function automatic logic [CfgDataW-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return CfgDataW'($urandom_range(0, 65535));
      default: return CfgDataW'($urandom_range(1, 24));
    endcase
  endfunction

  always @(posedge clk_i) begin
    key_report_t wanted;
    key_report_t seen;
    if (m_tvalid_o && m_tready_i) begin
      seen.press_edges   = m_tdata_o[OutEdgesLsb +: BitmapW];
      seen.held_keys     = m_tdata_o[OutHeldLsb +: BitmapW];
      seen.escape_hold   = m_tdata_o[OutEscapeBit];
      seen.confirm_hold  = m_tdata_o[OutConfirmBit];
      seen.increase_fire = m_tdata_o[OutIncBit];
      seen.decrease_fire = m_tdata_o[OutDecBit];
      if (expected_reports.size() == 0) begin
        $error("result transfer with no report expected: tdata %h", m_tdata_o);
        error_count++;
      end else begin
        wanted = expected_reports.pop_front();
        if (seen.press_edges !== wanted.press_edges) begin
          $error("press_edges: expected %h, actual %h", wanted.press_edges,
                 seen.press_edges);
          error_count++;
        end
        if (seen.held_keys !== wanted.held_keys) begin
          $error("held_keys: expected %h, actual %h", wanted.held_keys,
                 seen.held_keys);
          error_count++;
        end
        if (seen.escape_hold !== wanted.escape_hold) begin
          $error("escape_hold: expected %b, actual %b", wanted.escape_hold,
                 seen.escape_hold);
          error_count++;
        end
        if (seen.confirm_hold !== wanted.confirm_hold) begin
          $error("confirm_hold: expected %b, actual %b", wanted.confirm_hold,
                 seen.confirm_hold);
          error_count++;
        end
        if (seen.increase_fire !== wanted.increase_fire) begin
          $error("increase_fire: expected %b, actual %b", wanted.increase_fire,
                 seen.increase_fire);
          error_count++;
        end
        if (seen.decrease_fire !== wanted.decrease_fire) begin
          $error("decrease_fire: expected %b, actual %b", wanted.decrease_fire,
                 seen.decrease_fire);
          error_count++;
        end
        if (m_tdata_o[OutTdataW-1:OutUsedW] !== '0) begin
          $error("tdata padding: expected 0, actual %h",
                 m_tdata_o[OutTdataW-1:OutUsedW]);
          error_count++;
        end
      end
    end
  end

  // Reset thresholds: keys 0 to 3 stay held long enough to fire escape,
  // confirm and two repeat steps while row 1 walks through its patterns.
  task automatic run_default_thresholds();
    logic [3:0] row1_walk [4];
    row1_walk = '{4'h0, 4'hF, 4'h5, 4'hA};
    scan_tick(8'h00);
    scan_tick(8'hFF);
    for (int i = 0; i < 16; i++) scan_tick({row1_walk[i % 4], 4'hF});
    scan_tick(8'h00);
    scan_tick(8'h0F);
    scan_tick(8'hF0);
    scan_tick(8'h00);
  endtask

  // Zero, one and full-scale thresholds; the unused index must change nothing.
  task automatic run_threshold_bounds();
    program_thresholds('0, '0, '0);
    write_register(RegUnused, CfgDataW'($urandom_range(0, 65535)));
    random_scan(40);
    program_thresholds(16'd1, 16'd1, 16'd1);
    write_register(RegUnused, '1);
    random_scan(40);
    program_thresholds('1, '1, '1);
    random_scan(30);
  endtask

  task automatic run_random_scanning();
    for (int phase = 0; phase < 8; phase++) begin
      program_thresholds(pick_threshold(), pick_threshold(), pick_threshold());
      random_scan(227);
    end
  endtask

  initial begin
    for (int k = 0; k < NumKeys; k++) hold_count[k] = '0;
    thresholds.escape_hold_count  = EscapeHoldRst;
    thresholds.confirm_hold_count = ConfirmHoldRst;
    thresholds.repeat_start_count = RepeatStartRst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_default_thresholds();
    run_threshold_bounds();
    run_random_scanning();

    settle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("key_matrix_hold_repeat_unit test passed");
    end else begin
      $display("key_matrix_hold_repeat_unit test failed");
    end
    $finish;
  end

endmodule
